// File: hdl/lbm_d2q5_cardiac_cell_collide_defines.svh
// ----------------------------------------------------------------------------
// lbm_d2q5_cardiac_cell_collide_defines
// assertion macros used by the checker file of the collision block
// ----------------------------------------------------------------------------
`ifndef LBM_D2Q5_CARDIAC_CELL_COLLIDE_DEFINES_SVH
`define LBM_D2Q5_CARDIAC_CELL_COLLIDE_DEFINES_SVH

// clocked property, off while reset is low
`define LBMC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked property, checked during reset too
`define LBMC_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hdl/lbmc_pkg.sv
// ----------------------------------------------------------------------------
// lbmc_pkg
// types and constants of the d2q5 cardiac collision pipeline
// ----------------------------------------------------------------------------
package lbmc_pkg;

  localparam int FRAC_BITS = 30;
  localparam int NSTG      = 13;

  typedef logic [NSTG-1:0] stg_vec_t;

  // grid and stimulus windows
  localparam logic [12:0] GRID_ROWS = 13'd512;
  localparam logic [12:0] GRID_COLS = 13'd512;
  localparam logic [13:0] STEP_A_LO = 14'd1;
  localparam logic [13:0] STEP_A_HI = 14'd11;
  localparam logic [12:0] ROW_A_HI  = 13'd20;
  localparam logic [13:0] STEP_B_LO = 14'd3800;
  localparam logic [13:0] STEP_B_HI = 14'd3830;
  localparam logic [12:0] COL_B_HI  = 13'd100;

  // fixed point constants
  localparam longint ONE_L = longint'(1) << FRAC_BITS;
  localparam logic signed [35:0] ONE36    = 36'(ONE_L);
  localparam logic signed [33:0] ONE34    = 34'(ONE_L);
  localparam logic signed [31:0] C013     = 32'((13 * ONE_L + 50) / 100);
  localparam logic signed [35:0] STIM36   = 36'((ONE_L + 5) / 10);
  localparam logic signed [65:0] RND_HALF = 66'(ONE_L >> 1);
  localparam logic signed [35:0] SAT_HI   = 36'sd2147483647;
  localparam logic signed [35:0] SAT_LO   = -36'sd2147483648;

  // constant divisors: floor(2^33 / d), divisor, half divisor
  localparam logic [31:0] R3   = 32'd2863311530;
  localparam logic [31:0] R6   = 32'd1431655765;
  localparam logic [31:0] R120 = 32'd71582788;
  localparam logic [31:0] R150 = 32'd57266230;
  localparam logic [7:0]  D3   = 8'd3;
  localparam logic [7:0]  D6   = 8'd6;
  localparam logic [7:0]  D120 = 8'd120;
  localparam logic [7:0]  D150 = 8'd150;
  localparam logic [32:0] H3   = 33'd1;
  localparam logic [32:0] H6   = 33'd3;
  localparam logic [32:0] H120 = 33'd60;
  localparam logic [32:0] H150 = 33'd75;

  // register file
  typedef enum logic {
    REG_RELAX_RATE = 1'b0,
    REG_TIME_STEP  = 1'b1
  } reg_idx_e;

  localparam logic [30:0] RELAX_RATE_RST = 31'd1651910498;
  localparam logic [30:0] TIME_STEP_RST  = 31'd107374182;

  typedef struct packed {
    logic [30:0] relax_rate;
    logic [30:0] time_step;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] dist_rest;
    logic signed [31:0] dist_pos_x;
    logic signed [31:0] dist_pos_y;
    logic signed [31:0] dist_neg_x;
    logic signed [31:0] dist_neg_y;
    logic signed [31:0] gate_in;
    logic [8:0]         row;
    logic [8:0]         col;
    logic [13:0]        step;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] post_rest;
    logic signed [31:0] post_pos_x;
    logic signed [31:0] post_pos_y;
    logic signed [31:0] post_neg_x;
    logic signed [31:0] post_neg_y;
    logic signed [31:0] gate_out;
    logic signed [31:0] potential;
  } out_item_t;

endpackage

// File: hdl/lbmc_cfg.sv
// ----------------------------------------------------------------------------
// lbmc_cfg
// apb register file holding the relaxation rate and the time increment
// ----------------------------------------------------------------------------
module lbmc_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output lbmc_pkg::cfg_t     cfg_o
);

  lbmc_pkg::cfg_t     cfg_q;
  lbmc_pkg::cfg_t     cfg_d;
  lbmc_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = lbmc_pkg::reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        lbmc_pkg::REG_RELAX_RATE: cfg_d.relax_rate = pwdata[30:0];
        lbmc_pkg::REG_TIME_STEP:  cfg_d.time_step  = pwdata[30:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lbmc_pkg::REG_RELAX_RATE: prdata = {1'b0, cfg_q.relax_rate};
      lbmc_pkg::REG_TIME_STEP:  prdata = {1'b0, cfg_q.time_step};
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.relax_rate <= lbmc_pkg::RELAX_RATE_RST;
      cfg_q.time_step  <= lbmc_pkg::TIME_STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/lbmc_flow.sv
// ----------------------------------------------------------------------------
// lbmc_flow
// valid bits and stage enables of the collision pipeline, bubbles collapse
// ----------------------------------------------------------------------------
module lbmc_flow (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lbmc_pkg::stg_vec_t stage_en_o
);

  lbmc_pkg::stg_vec_t valid_q;
  lbmc_pkg::stg_vec_t valid_d;
  lbmc_pkg::stg_vec_t en;

  // a stage may load when the output is not stalled or some stage from it to the output is empty
  always_comb begin
    for (int k = 0; k < lbmc_pkg::NSTG; k++) begin
      en[k] = !out_stall_i ||
              !(&(valid_q | ((lbmc_pkg::stg_vec_t'(1) << k) - lbmc_pkg::stg_vec_t'(1))));
    end
  end

  always_comb begin
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < lbmc_pkg::NSTG; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[lbmc_pkg::NSTG-1];
  assign stage_en_o  = en;

endmodule

// File: hdl/lbmc_datapath.sv
// ----------------------------------------------------------------------------
// lbmc_datapath
// thirteen stage arithmetic of the collision: potential, ionic current,
// gate update and relaxation, no two multiplies or corrections chained in a stage
// ----------------------------------------------------------------------------
module lbmc_datapath (
  input  logic                clk_i,
  input  lbmc_pkg::in_item_t  in_data_i,
  input  lbmc_pkg::cfg_t      cfg_i,
  input  lbmc_pkg::stg_vec_t  stage_en_i,
  output lbmc_pkg::out_item_t out_data_o
);

  typedef struct packed {
    logic [4:0][31:0]   f;
    logic signed [31:0] h;
    logic signed [31:0] v;
    logic               stim;
    logic               vneg;
    logic [32:0]        eqm3;
    logic [32:0]        eqm6;
    logic [31:0]        eqq3;
    logic [31:0]        eqq6;
    logic               dhneg;
    logic               dhsel;
    logic [32:0]        dhm;
    logic [31:0]        dhq;
    logic signed [63:0] vvp;
    logic signed [31:0] omv;
    logic signed [31:0] vv;
    logic signed [31:0] eq0;
    logic signed [31:0] eq;
    logic signed [31:0] dh;
    logic signed [63:0] cp;
    logic signed [63:0] dtp;
    logic [4:0][65:0]   op;
    logic signed [31:0] c;
    logic signed [31:0] gate;
    logic [4:0][35:0]   pk;
    logic signed [63:0] hcp;
    logic               pneg;
    logic [31:0]        pa;
    logic [32:0]        im;
    logic [31:0]        iqq;
    logic signed [35:0] iin;
    logic signed [31:0] cur;
    logic signed [63:0] sp;
    logic               sneg;
    logic [32:0]        sm3;
    logic [32:0]        sm6;
    logic [31:0]        sq3;
    logic [31:0]        sq6;
    logic signed [31:0] src0;
    logic signed [31:0] src;
    logic [4:0][31:0]   post;
  } rec_t;

  rec_t st_q [lbmc_pkg::NSTG];
  rec_t st_d [lbmc_pkg::NSTG];

  // round half up after the fraction shift
  function automatic logic signed [35:0] rnd_q(input logic signed [65:0] x);
    logic signed [65:0] t;
    t = x + lbmc_pkg::RND_HALF;
    return t[lbmc_pkg::FRAC_BITS +: 36];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    if (x > lbmc_pkg::SAT_HI) return 32'sh7fffffff;
    if (x < lbmc_pkg::SAT_LO) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic [32:0] mag33(input logic signed [31:0] x);
    logic [32:0] e;
    e = {x[31], x};
    return x[31] ? (33'd0 - e) : e;
  endfunction

  // quotient estimate, low by at most one
  function automatic logic [31:0] recip_q(input logic [32:0] m, input logic [31:0] r);
    logic [64:0] p;
    p = {32'd0, m} * {33'd0, r};
    return p[64:33];
  endfunction

  function automatic logic [31:0] div_fix(input logic [32:0] m, input logic [31:0] qp,
                                          input logic [7:0] d);
    logic [39:0] prod;
    logic [39:0] rem;
    prod = {8'd0, qp} * {32'd0, d};
    rem  = {7'd0, m} - prod;
    if (rem >= {32'd0, d}) return qp + 32'd1;
    return qp;
  endfunction

  function automatic logic signed [31:0] sgn32(input logic neg, input logic [31:0] q);
    return neg ? (32'd0 - q) : q;
  endfunction

  always_comb begin
    logic signed [31:0] omega;
    logic signed [31:0] dtv;
    logic signed [31:0] eqk;
    logic signed [31:0] srck;
    logic signed [32:0] diff;
    logic signed [35:0] sum;
    logic signed [33:0] dhn;
    logic [33:0]        dhmag;
    logic               lowv;
    logic [31:0]        iq;
    logic [33:0]        ia;
    logic               win_a;
    logic               win_b;

    omega = $signed({1'b0, cfg_i.relax_rate});
    dtv   = $signed({1'b0, cfg_i.time_step});

    // potential and stimulus
    st_d[0]      = '0;
    st_d[0].f[0] = in_data_i.dist_rest;
    st_d[0].f[1] = in_data_i.dist_pos_x;
    st_d[0].f[2] = in_data_i.dist_pos_y;
    st_d[0].f[3] = in_data_i.dist_neg_x;
    st_d[0].f[4] = in_data_i.dist_neg_y;
    st_d[0].h    = in_data_i.gate_in;
    sum = 36'(in_data_i.dist_rest) + 36'(in_data_i.dist_pos_x) +
          36'(in_data_i.dist_pos_y) + 36'(in_data_i.dist_neg_x) +
          36'(in_data_i.dist_neg_y);
    st_d[0].v = sat32(sum);
    win_a = (in_data_i.step >= lbmc_pkg::STEP_A_LO) && (in_data_i.step <= lbmc_pkg::STEP_A_HI)
         && (in_data_i.row != 9'd0) && ({4'd0, in_data_i.row} < lbmc_pkg::ROW_A_HI)
         && (in_data_i.col != 9'd0) && ({4'd0, in_data_i.col} < lbmc_pkg::GRID_COLS);
    win_b = (in_data_i.step >= lbmc_pkg::STEP_B_LO) && (in_data_i.step <= lbmc_pkg::STEP_B_HI)
         && (in_data_i.row != 9'd0) && ({4'd0, in_data_i.row} < lbmc_pkg::GRID_ROWS)
         && (in_data_i.col != 9'd0) && ({4'd0, in_data_i.col} < lbmc_pkg::COL_B_HI);
    st_d[0].stim = win_a || win_b;

    // v squared, equilibrium and gate rate quotient estimates
    st_d[1]      = st_q[0];
    st_d[1].vvp  = 64'(st_q[0].v) * 64'(st_q[0].v);
    st_d[1].omv  = sat32(lbmc_pkg::ONE36 - 36'(st_q[0].v));
    st_d[1].vneg = st_q[0].v[31];
    st_d[1].eqm3 = mag33(st_q[0].v) + lbmc_pkg::H3;
    st_d[1].eqm6 = mag33(st_q[0].v) + lbmc_pkg::H6;
    st_d[1].eqq3 = recip_q(st_d[1].eqm3, lbmc_pkg::R3);
    st_d[1].eqq6 = recip_q(st_d[1].eqm6, lbmc_pkg::R6);
    lowv  = st_q[0].v < lbmc_pkg::C013;
    dhn   = lowv ? (lbmc_pkg::ONE34 - 34'(st_q[0].h)) : (34'sd0 - 34'(st_q[0].h));
    dhmag = dhn[33] ? (34'd0 - $unsigned(dhn)) : $unsigned(dhn);
    st_d[1].dhneg = dhn[33];
    st_d[1].dhsel = lowv;
    st_d[1].dhm   = dhmag[32:0] + (lowv ? lbmc_pkg::H120 : lbmc_pkg::H150);
    st_d[1].dhq   = recip_q(st_d[1].dhm, lowv ? lbmc_pkg::R120 : lbmc_pkg::R150);

    // quotient corrections
    st_d[2]     = st_q[1];
    st_d[2].vv  = sat32(rnd_q(66'(st_q[1].vvp)));
    st_d[2].eq0 = sgn32(st_q[1].vneg, div_fix(st_q[1].eqm3, st_q[1].eqq3, lbmc_pkg::D3));
    st_d[2].eq  = sgn32(st_q[1].vneg, div_fix(st_q[1].eqm6, st_q[1].eqq6, lbmc_pkg::D6));
    st_d[2].dh  = sgn32(st_q[1].dhneg, div_fix(st_q[1].dhm, st_q[1].dhq,
                        st_q[1].dhsel ? lbmc_pkg::D120 : lbmc_pkg::D150));

    // cubic term, gate step, relaxation products
    st_d[3]     = st_q[2];
    st_d[3].cp  = 64'(st_q[2].vv) * 64'(st_q[2].omv);
    st_d[3].dtp = 64'(dtv) * 64'(st_q[2].dh);
    for (int k = 0; k < 5; k++) begin
      eqk  = (k == 0) ? st_q[2].eq0 : st_q[2].eq;
      diff = 33'(eqk) - 33'($signed(st_q[2].f[k]));
      st_d[3].op[k] = 66'(omega) * 66'(diff);
    end

    st_d[4]      = st_q[3];
    st_d[4].c    = sat32(rnd_q(66'(st_q[3].cp)));
    st_d[4].gate = sat32(36'(st_q[3].h) + rnd_q(66'(st_q[3].dtp)));
    for (int k = 0; k < 5; k++) begin
      st_d[4].pk[k] = 36'($signed(st_q[3].f[k])) + rnd_q($signed(st_q[3].op[k]));
    end

    st_d[5]     = st_q[4];
    st_d[5].hcp = 64'(st_q[4].h) * 64'(st_q[4].c);

    // inward current times ten thirds
    st_d[6]      = st_q[5];
    st_d[6].pneg = st_q[5].hcp[63];
    begin
      logic signed [31:0] p;
      logic [32:0]        pm;
      p  = sat32(rnd_q(66'(st_q[5].hcp)));
      pm = mag33(p);
      st_d[6].pneg = p[31];
      st_d[6].pa   = pm[31:0];
      st_d[6].im   = pm + lbmc_pkg::H3;
      st_d[6].iqq  = recip_q(st_d[6].im, lbmc_pkg::R3);
    end

    st_d[7] = st_q[6];
    iq = div_fix(st_q[6].im, st_q[6].iqq, lbmc_pkg::D3);
    ia = 34'(st_q[6].pa) * 34'd3 + 34'(iq);
    st_d[7].iin = st_q[6].pneg ? (36'sd0 - $signed(36'(ia))) : $signed(36'(ia));

    st_d[8]     = st_q[7];
    st_d[8].cur = sat32(st_q[7].iin - 36'(st_q[7].eq) +
                        (st_q[7].stim ? lbmc_pkg::STIM36 : 36'sd0));

    st_d[9]    = st_q[8];
    st_d[9].sp = 64'(dtv) * 64'(st_q[8].cur);

    // source term quotient estimates
    st_d[10] = st_q[9];
    begin
      logic signed [31:0] s;
      s = sat32(rnd_q(66'(st_q[9].sp)));
      st_d[10].sneg = s[31];
      st_d[10].sm3  = mag33(s) + lbmc_pkg::H3;
      st_d[10].sm6  = mag33(s) + lbmc_pkg::H6;
      st_d[10].sq3  = recip_q(st_d[10].sm3, lbmc_pkg::R3);
      st_d[10].sq6  = recip_q(st_d[10].sm6, lbmc_pkg::R6);
    end

    st_d[11]      = st_q[10];
    st_d[11].src0 = sgn32(st_q[10].sneg, div_fix(st_q[10].sm3, st_q[10].sq3, lbmc_pkg::D3));
    st_d[11].src  = sgn32(st_q[10].sneg, div_fix(st_q[10].sm6, st_q[10].sq6, lbmc_pkg::D6));

    st_d[12] = st_q[11];
    for (int k = 0; k < 5; k++) begin
      srck = (k == 0) ? st_q[11].src0 : st_q[11].src;
      st_d[12].post[k] = sat32($signed(st_q[11].pk[k]) + 36'(srck));
    end
  end

  for (genvar k = 0; k < lbmc_pkg::NSTG; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (stage_en_i[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign out_data_o.post_rest  = st_q[lbmc_pkg::NSTG-1].post[0];
  assign out_data_o.post_pos_x = st_q[lbmc_pkg::NSTG-1].post[1];
  assign out_data_o.post_pos_y = st_q[lbmc_pkg::NSTG-1].post[2];
  assign out_data_o.post_neg_x = st_q[lbmc_pkg::NSTG-1].post[3];
  assign out_data_o.post_neg_y = st_q[lbmc_pkg::NSTG-1].post[4];
  assign out_data_o.gate_out   = st_q[lbmc_pkg::NSTG-1].gate;
  assign out_data_o.potential  = st_q[lbmc_pkg::NSTG-1].v;

endmodule

// File: hdl/lbm_d2q5_cardiac_cell_collide.sv
// ----------------------------------------------------------------------------
// lbm_d2q5_cardiac_cell_collide
// d2q5 lattice boltzmann collision with mitchell-schaeffer reaction, per cell
// ----------------------------------------------------------------------------
// One cell enters per clock while the input is not stalled; the
// throughput is one cell per cycle as long as the output is not stalled.
// The stage count follows the dependency chain v -> v*v -> cubic term
// -> h times cubic term -> current -> source term -> new distributions, with
// no two multiplies or corrections chained in a stage. Empty stages close up
// while the output is stalled, so the input stalls only once every stage
// holds a cell. Write relax_rate and time_step only with no cell in flight.
module lbm_d2q5_cardiac_cell_collide (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lbmc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lbmc_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  lbmc_pkg::cfg_t     cfg;
  lbmc_pkg::stg_vec_t stage_en;

  lbmc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lbmc_flow u_flow (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stage_en_o  (stage_en)
  );

  lbmc_datapath u_datapath (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .stage_en_i (stage_en),
    .out_data_o (out_data_o)
  );

endmodule

// File: hdl/lbmc_checker.sv
// ----------------------------------------------------------------------------
// lbmc_checker
// port level checks of the collision block, bound to the top level
// ----------------------------------------------------------------------------
`include "lbm_d2q5_cardiac_cell_collide_defines.svh"

module lbmc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input lbmc_pkg::out_item_t out_data_o
);

  `LBMC_ASSERT_RST(a_idle_in_reset, !rst_ni |-> !out_valid_o, "result valid during reset")
  `LBMC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "stalled result dropped")
  `LBMC_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_data_o), "stalled result changed")
  `LBMC_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled with room left")

endmodule

bind lbm_d2q5_cardiac_cell_collide lbmc_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
